// File: rtl/core/fused_radix6_real_dft_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fused radix-6 real DFT
// Clocked concurrent assertion forms used by the block's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef FUSED_RADIX6_REAL_DFT_DEFINES_SVH
`define FUSED_RADIX6_REAL_DFT_DEFINES_SVH

// check while out of reset
`define FRDFT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check through reset as well
`define FRDFT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/frdft_pkg.sv
// ----------------------------------------------------------------------------
// Fused radix-6 real DFT package
// Shared types, constants and coefficient helper for the butterfly.
// ----------------------------------------------------------------------------
package frdft_pkg;

  localparam int NUM_POINTS             = 12;
  localparam int RESULT_WIDTH           = 20;
  localparam int DEFAULT_SAMPLE_WIDTH   = 16;
  localparam int DEFAULT_COEF_FRAC_BITS = 15;

  localparam int RES_MAX = (1 << (RESULT_WIDTH - 1)) - 1;
  localparam int RES_MIN = -(1 << (RESULT_WIDTH - 1));

  // weights in Q32
  localparam logic [63:0] HALF_Q32   = 64'd2147483648;
  localparam logic [63:0] R3HALF_Q32 = 64'd3719550787;
  localparam logic [63:0] R3_Q32     = 64'd7439101574;

  localparam int CFG_ADDR_W = 3;
  localparam logic REG_DIRECTION = 1'b0;

  typedef enum logic {
    DIR_FORWARD  = 1'b0,
    DIR_BACKWARD = 1'b1
  } dir_t;

  // round a Q32 weight to frac fractional bits
  function automatic logic [63:0] coef_q(input logic [63:0] q32, input int unsigned frac);
    return (q32 + (64'd1 << (31 - frac))) >> (32 - frac);
  endfunction

endpackage

// File: rtl/core/frdft_cfg.sv
// ----------------------------------------------------------------------------
// Fused radix-6 real DFT configuration registers
// APB-style register port holding the transform direction.
// ----------------------------------------------------------------------------
module frdft_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [frdft_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output frdft_pkg::dir_t                  direction
);
  import frdft_pkg::*;

  logic write_hit;

  assign pready    = 1'b1;
  assign write_hit = psel && penable && pwrite && (paddr[2] == REG_DIRECTION);

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_FORWARD;
    end else if (write_hit) begin
      direction <= dir_t'(pwdata[0]);
    end
  end

  always_comb begin
    if (paddr[2] == REG_DIRECTION) begin
      prdata = {31'b0, direction};
    end else begin
      prdata = '0;
    end
  end

endmodule

// File: rtl/core/frdft_mulr.sv
// ----------------------------------------------------------------------------
// Fused radix-6 real DFT constant multiplier
// Multiplies by a fixed weight and rounds to nearest, ties upward.
// ----------------------------------------------------------------------------
module frdft_mulr #(
  parameter int          WIDTH = 20,
  parameter int          FRAC  = 15,
  parameter logic [63:0] COEF  = 64'd16384
) (
  input  logic signed [WIDTH-1:0] x,
  output logic signed [WIDTH-1:0] y
);

  localparam int CW = FRAC + 2;
  localparam int PW = WIDTH + CW;
  localparam logic signed [CW-1:0] C = CW'(COEF);
  localparam logic signed [PW-1:0] ROUND = PW'(64'd1 << (FRAC - 1));

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rounded;

  assign prod    = x * C;
  assign rounded = prod + ROUND;
  assign y       = rounded[FRAC +: WIDTH];

endmodule

// File: rtl/core/frdft_butterfly.sv
// ----------------------------------------------------------------------------
// Fused radix-6 real DFT butterfly
// Forward and backward fused radix-6 equations on one 12-sample vector,
// followed by saturation to the result width.
// ----------------------------------------------------------------------------
module frdft_butterfly #(
  parameter int SAMPLE_WIDTH   = frdft_pkg::DEFAULT_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = frdft_pkg::DEFAULT_COEF_FRAC_BITS
) (
  input  logic [frdft_pkg::NUM_POINTS*SAMPLE_WIDTH-1:0]          samples,
  input  frdft_pkg::dir_t                                        direction,
  output logic [frdft_pkg::NUM_POINTS*frdft_pkg::RESULT_WIDTH-1:0] results
);
  import frdft_pkg::*;

  localparam int WW = SAMPLE_WIDTH + 4;
  localparam int EW = (WW >= RESULT_WIDTH) ? WW + 1 : RESULT_WIDTH + 1;
  localparam logic [63:0] C_HALF   = coef_q(HALF_Q32, COEF_FRAC_BITS);
  localparam logic [63:0] C_R3HALF = coef_q(R3HALF_Q32, COEF_FRAC_BITS);
  localparam logic [63:0] C_R3     = coef_q(R3_Q32, COEF_FRAC_BITS);
  localparam logic signed [EW-1:0] SAT_HI = EW'(RES_MAX);
  localparam logic signed [EW-1:0] SAT_LO = EW'(RES_MIN);

  typedef logic signed [WW-1:0] word_t;

  word_t x [NUM_POINTS];
  word_t y [NUM_POINTS];
  logic signed [EW-1:0] ext [NUM_POINTS];

  always_comb begin
    for (int i = 0; i < NUM_POINTS; i++) begin
      x[i] = WW'($signed(samples[i*SAMPLE_WIDTH +: SAMPLE_WIDTH]));
    end
  end

  // forward
  word_t f_s0, f_d0, f_s1, f_d1, f_s2, f_d2, f_ss, f_dd, f_ds, f_dd2;
  word_t f_e0, f_e1, f_e2, f_e3, f_p0, f_p1, f_p2, f_p3;
  word_t f_m3, f_m4, f_m7, f_m8, f_u, f_v;

  assign f_s0  = x[0] + x[6];
  assign f_d0  = x[0] - x[6];
  assign f_s1  = x[2] + x[4];
  assign f_d1  = x[2] - x[4];
  assign f_s2  = x[10] + x[8];
  assign f_d2  = x[10] - x[8];
  assign f_ss  = f_s1 + f_s2;
  assign f_dd  = f_d1 + f_d2;
  assign f_ds  = f_s2 - f_s1;
  assign f_dd2 = f_d2 - f_d1;
  assign f_e0  = x[3] - x[11];
  assign f_e1  = x[3] + x[11];
  assign f_e2  = x[5] - x[9];
  assign f_e3  = x[5] + x[9];
  assign f_u   = x[1] + f_p2;
  assign f_v   = x[7] + f_p1;

  frdft_mulr #(.WIDTH(WW), .FRAC(COEF_FRAC_BITS), .COEF(C_R3HALF)) u_f_p0 (.x(f_e0), .y(f_p0));
  frdft_mulr #(.WIDTH(WW), .FRAC(COEF_FRAC_BITS), .COEF(C_HALF))   u_f_p1 (.x(f_e1), .y(f_p1));
  frdft_mulr #(.WIDTH(WW), .FRAC(COEF_FRAC_BITS), .COEF(C_HALF))   u_f_p2 (.x(f_e2), .y(f_p2));
  frdft_mulr #(.WIDTH(WW), .FRAC(COEF_FRAC_BITS), .COEF(C_R3HALF)) u_f_p3 (.x(f_e3), .y(f_p3));
  frdft_mulr #(.WIDTH(WW), .FRAC(COEF_FRAC_BITS), .COEF(C_HALF))   u_f_m3 (.x(f_dd), .y(f_m3));
  frdft_mulr #(.WIDTH(WW), .FRAC(COEF_FRAC_BITS), .COEF(C_R3HALF)) u_f_m4 (.x(f_ds), .y(f_m4));
  frdft_mulr #(.WIDTH(WW), .FRAC(COEF_FRAC_BITS), .COEF(C_HALF))   u_f_m7 (.x(f_ss), .y(f_m7));
  frdft_mulr #(.WIDTH(WW), .FRAC(COEF_FRAC_BITS), .COEF(C_R3HALF)) u_f_m8 (.x(f_dd2), .y(f_m8));

  // backward
  word_t b_s0, b_d0, b_s1, b_d1, b_s2, b_d2, b_m0, b_m1, b_f, b_g;
  word_t b_t0, b_t3, b_x04, b_x15, b_t1, b_t4, b_w0, b_w1, b_w2, b_w3, b_h, b_k;

  assign b_s0  = x[0] + x[11];
  assign b_d0  = x[0] - x[11];
  assign b_s1  = x[3] + x[7];
  assign b_d1  = x[3] - x[7];
  assign b_s2  = x[4] + x[8];
  assign b_d2  = x[4] - x[8];
  assign b_f   = b_d0 + b_d1;
  assign b_g   = b_s0 - b_s1;
  assign b_t0  = x[1] + x[9];
  assign b_x04 = x[1] - x[9];
  assign b_t3  = x[2] + x[10];
  assign b_x15 = x[2] - x[10];
  assign b_w0  = b_t0 <<< 1;
  assign b_w1  = b_t3 <<< 1;
  assign b_w2  = x[5] <<< 1;
  assign b_w3  = x[6] <<< 1;
  assign b_h   = b_t3 + b_w3;
  assign b_k   = b_t0 - b_w2;

  frdft_mulr #(.WIDTH(WW), .FRAC(COEF_FRAC_BITS), .COEF(C_R3)) u_b_m0 (.x(b_s2), .y(b_m0));
  frdft_mulr #(.WIDTH(WW), .FRAC(COEF_FRAC_BITS), .COEF(C_R3)) u_b_m1 (.x(b_d2), .y(b_m1));
  frdft_mulr #(.WIDTH(WW), .FRAC(COEF_FRAC_BITS), .COEF(C_R3)) u_b_t1 (.x(b_x04), .y(b_t1));
  frdft_mulr #(.WIDTH(WW), .FRAC(COEF_FRAC_BITS), .COEF(C_R3)) u_b_t4 (.x(b_x15), .y(b_t4));

  always_comb begin
    if (direction == DIR_FORWARD) begin
      y[0]  = f_s0 + f_ss;
      y[3]  = f_d0 + f_m3;
      y[4]  = f_m4;
      y[7]  = f_s0 - f_m7;
      y[8]  = f_m8;
      y[11] = f_d0 - f_dd;
      y[1]  = f_u + f_p0;
      y[2]  = -f_p3 - f_v;
      y[5]  = x[1] - f_e2;
      y[6]  = x[7] - f_e1;
      y[9]  = f_u - f_p0;
      y[10] = f_p3 - f_v;
    end else begin
      y[0]  = b_s0 + (b_s1 <<< 1);
      y[2]  = b_f - b_m0;
      y[4]  = b_g - b_m1;
      y[6]  = b_d0 - (b_d1 <<< 1);
      y[8]  = b_g + b_m1;
      y[10] = b_f + b_m0;
      y[1]  = b_w2 + b_w0;
      y[3]  = b_t1 - b_h;
      y[5]  = b_k - b_t4;
      y[7]  = b_w3 - b_w1;
      y[9]  = -b_k - b_t4;
      y[11] = -b_t1 - b_h;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_POINTS; i++) begin
      ext[i] = EW'(y[i]);
      if (ext[i] > SAT_HI) begin
        results[i*RESULT_WIDTH +: RESULT_WIDTH] = SAT_HI[RESULT_WIDTH-1:0];
      end else if (ext[i] < SAT_LO) begin
        results[i*RESULT_WIDTH +: RESULT_WIDTH] = SAT_LO[RESULT_WIDTH-1:0];
      end else begin
        results[i*RESULT_WIDTH +: RESULT_WIDTH] = ext[i][RESULT_WIDTH-1:0];
      end
    end
  end

endmodule

// File: rtl/core/fused_radix6_real_dft.sv
// ----------------------------------------------------------------------------
// Fused radix-6 real DFT
// Streaming 12-point real transform built from two interleaved size-6 DFTs.
// ----------------------------------------------------------------------------
// The block takes one 12-sample vector per clock and returns one 12-value
// result per vector, in order. A request is accepted into an input register,
// and its result is loaded into the output register once that register is
// empty or its current result is being taken; m_tvalid rises with that load.
// The sustained rate is one vector per cycle, because a single combinational
// butterfly sits between the two registers. When the receiver stalls, the
// output register holds its result. The input register takes one more
// request and then drops s_tready. The direction register selects the
// forward or backward equations. Write it over the APB port only while no
// request is in flight.
`include "fused_radix6_real_dft_defines.svh"

module fused_radix6_real_dft #(
  parameter int SAMPLE_WIDTH   = frdft_pkg::DEFAULT_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = frdft_pkg::DEFAULT_COEF_FRAC_BITS
) (
  input  logic                                                       clk,
  input  logic                                                       rst,
  // sample_0 .. sample_11, SAMPLE_WIDTH bits each, zero padded to bytes
  input  logic [((frdft_pkg::NUM_POINTS*SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,
  input  logic                                                       s_tvalid,
  output logic                                                       s_tready,
  // result_0 .. result_11, 20 bits each
  output logic [((frdft_pkg::NUM_POINTS*frdft_pkg::RESULT_WIDTH+7)/8)*8-1:0] m_tdata,
  output logic                                                       m_tvalid,
  input  logic                                                       m_tready,
  input  logic                                                       psel,
  input  logic                                                       penable,
  input  logic                                                       pwrite,
  input  logic [frdft_pkg::CFG_ADDR_W-1:0]                           paddr,
  input  logic [31:0]                                                pwdata,
  output logic [31:0]                                                prdata,
  output logic                                                       pready
);
  import frdft_pkg::*;

  localparam int IN_BITS  = NUM_POINTS * SAMPLE_WIDTH;
  localparam int RES_BITS = NUM_POINTS * RESULT_WIDTH;
  localparam int OUT_W    = ((RES_BITS + 7) / 8) * 8;

  dir_t               direction;
  logic               stage_valid;
  logic [IN_BITS-1:0] stage_data;
  logic               advance;
  logic [RES_BITS-1:0] results;

  frdft_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .direction (direction)
  );

  frdft_butterfly #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_butterfly (
    .samples   (stage_data),
    .direction (direction),
    .results   (results)
  );

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stage_data <= s_tdata[IN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      m_tdata <= OUT_W'(results);
    end
  end

  `FRDFT_ASSERT_RST(a_reset_empty, rst |=> (!m_tvalid && !stage_valid), "pipeline not empty after reset")
  `FRDFT_ASSERT(a_stage_hold, (stage_valid && !advance) |=> (stage_valid && $stable(stage_data)), "input stage lost a held request")
  `FRDFT_ASSERT(a_stage_move, (stage_valid && advance) |=> m_tvalid, "request dropped between stages")
  `FRDFT_ASSERT(a_full_block, (m_tvalid && !m_tready && stage_valid) |-> !s_tready, "request accepted into a full pipeline")

endmodule

// File: bench/fused_radix6_real_dft_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fused radix-6 real DFT testbench
// Streams 12-sample vectors through the butterfly in both directions and
// compares every 20-bit result against a bit-exact fixed-point predictor.
// Covers directed extremes, random bursts, receiver stalls with two long
// hold-offs that back up the input, and APB writes to the direction register.
// ----------------------------------------------------------------------------
module fused_radix6_real_dft_tb;
  import frdft_pkg::*;

  localparam int SAMPLE_W    = DEFAULT_SAMPLE_WIDTH;
  localparam int COEF_BITS   = DEFAULT_COEF_FRAC_BITS;
  localparam int SDATA_W     = ((NUM_POINTS * SAMPLE_W + 7) / 8) * 8;
  localparam int RDATA_W     = ((NUM_POINTS * RESULT_WIDTH + 7) / 8) * 8;
  localparam int REG_UNMAPPED = 1;
  localparam logic [CFG_ADDR_W-1:0] ADDR_DIRECTION = CFG_ADDR_W'(4 * int'(REG_DIRECTION));
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED  = CFG_ADDR_W'(4 * REG_UNMAPPED);

  localparam longint W_HALF   = longint'((HALF_Q32 + (64'd1 << (31 - COEF_BITS))) >> (32 - COEF_BITS));
  localparam longint W_R3HALF = longint'((R3HALF_Q32 + (64'd1 << (31 - COEF_BITS))) >> (32 - COEF_BITS));
  localparam longint W_R3     = longint'((R3_Q32 + (64'd1 << (31 - COEF_BITS))) >> (32 - COEF_BITS));

  localparam logic [SAMPLE_W-1:0] SMAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SMIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  localparam int DIRECTED     = 10;
  localparam int PHASE_ITEMS  = 210;
  localparam int PHASES       = 4;
  localparam int HOLD_CYCLES  = 120;
  localparam int CYCLE_LIMIT  = 200000;

  class vector_scoreboard;
    dir_t direction;
    logic [RDATA_W-1:0] pending_results[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      direction = DIR_FORWARD;
      errors = 0;
      checked = 0;
    endfunction

    task report(input string msg);
      if (errors < 40) $display("%0t: mismatch: %s", $time, msg);
      errors++;
    endtask

    static function longint weigh(input longint x, input longint w);
      longint p;
      p = x * w + (longint'(1) << (COEF_BITS - 1));
      return p >>> COEF_BITS;
    endfunction

    static function logic [RESULT_WIDTH-1:0] clip(input longint v);
      if (v > RES_MAX) return RESULT_WIDTH'(RES_MAX);
      if (v < RES_MIN) return RESULT_WIDTH'(RES_MIN);
      return RESULT_WIDTH'(v);
    endfunction

    function logic [RDATA_W-1:0] transform_vector(input logic [SDATA_W-1:0] d);
      longint x[NUM_POINTS];
      longint y[NUM_POINTS];
      longint s0, d0, s1, d1, s2, d2, ss, dd;
      longint e0, e1, e2, e3, p0, p1, p2, p3, u, v;
      longint m0, m1, f, g, t0, t1, t3, t4, h, k;
      logic [RDATA_W-1:0] r;
      int i;
      for (i = 0; i < NUM_POINTS; i++)
        x[i] = longint'($signed(d[i*SAMPLE_W +: SAMPLE_W]));
      if (direction == DIR_FORWARD) begin
        s0 = x[0] + x[6];   d0 = x[0] - x[6];
        s1 = x[2] + x[4];   d1 = x[2] - x[4];
        s2 = x[10] + x[8];  d2 = x[10] - x[8];
        ss = s1 + s2;       dd = d1 + d2;
        e0 = x[3] - x[11];  e1 = x[3] + x[11];
        e2 = x[5] - x[9];   e3 = x[5] + x[9];
        p0 = weigh(e0, W_R3HALF);
        p1 = weigh(e1, W_HALF);
        p2 = weigh(e2, W_HALF);
        p3 = weigh(e3, W_R3HALF);
        u = x[1] + p2;
        v = x[7] + p1;
        y[0]  = s0 + ss;
        y[3]  = d0 + weigh(dd, W_HALF);
        y[4]  = weigh(s2 - s1, W_R3HALF);
        y[7]  = s0 - weigh(ss, W_HALF);
        y[8]  = weigh(d2 - d1, W_R3HALF);
        y[11] = d0 - dd;
        y[1]  = u + p0;
        y[2]  = -p3 - v;
        y[5]  = x[1] - e2;
        y[6]  = x[7] - e1;
        y[9]  = u - p0;
        y[10] = p3 - v;
      end else begin
        s0 = x[0] + x[11];  d0 = x[0] - x[11];
        s1 = x[3] + x[7];   d1 = x[3] - x[7];
        s2 = x[4] + x[8];   d2 = x[4] - x[8];
        m0 = weigh(s2, W_R3);
        m1 = weigh(d2, W_R3);
        f = d0 + d1;
        g = s0 - s1;
        t0 = x[1] + x[9];
        t1 = weigh(x[1] - x[9], W_R3);
        t3 = x[2] + x[10];
        t4 = weigh(x[2] - x[10], W_R3);
        h = t3 + 2 * x[6];
        k = t0 - 2 * x[5];
        y[0]  = s0 + 2 * s1;
        y[2]  = f - m0;
        y[4]  = g - m1;
        y[6]  = d0 - 2 * d1;
        y[8]  = g + m1;
        y[10] = f + m0;
        y[1]  = 2 * x[5] + 2 * t0;
        y[3]  = t1 - h;
        y[5]  = k - t4;
        y[7]  = 2 * x[6] - 2 * t3;
        y[9]  = -k - t4;
        y[11] = -t1 - h;
      end
      r = '0;
      for (i = 0; i < NUM_POINTS; i++)
        r[i*RESULT_WIDTH +: RESULT_WIDTH] = clip(y[i]);
      return r;
    endfunction

    function void note_request(input logic [SDATA_W-1:0] d);
      pending_results.push_back(transform_vector(d));
    endfunction

    task check_result(input logic [RDATA_W-1:0] got);
      logic [RDATA_W-1:0] want;
      int i;
      if (pending_results.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        checked++;
        for (i = 0; i < NUM_POINTS; i++)
          if (got[i*RESULT_WIDTH +: RESULT_WIDTH] !== want[i*RESULT_WIDTH +: RESULT_WIDTH])
            report($sformatf("vector %0d result_%0d: got %0d, want %0d", checked, i,
                             $signed(got[i*RESULT_WIDTH +: RESULT_WIDTH]),
                             $signed(want[i*RESULT_WIDTH +: RESULT_WIDTH])));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic [SDATA_W-1:0]    s_tdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [RDATA_W-1:0]    m_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  vector_scoreboard sb;
  int unsigned n_accepted;
  int unsigned burst_left;
  int unsigned holds_done;
  int unsigned hold_left;
  int unsigned stall_left;
  int unsigned cycle_count;
  logic        stall_free;
  logic [31:0] stall_pattern;

  fused_radix6_real_dft u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fused_radix6_real_dft_tb: timed out after %0d cycles", cycle_count);
      $display("fused_radix6_real_dft_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_request(s_tdata);
        n_accepted++;
      end
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  // receiver: random stall patterns, free-running stretches, two long hold-offs
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (holds_done < 2 && n_accepted >= 100 + 400 * holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else begin
        if (stall_left == 0) begin
          stall_left = $urandom_range(16, 120);
          stall_free = ($urandom_range(0, 3) == 0);
          stall_pattern = $urandom;
        end
        stall_left--;
        m_tready <= stall_free ? 1'b1 : stall_pattern[stall_left % 32];
      end
    end
  end

  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_vector(input logic [SDATA_W-1:0] d);
    pace_sender();
    s_tdata  <= d;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_DIRECTION) sb.direction = dir_t'(value[0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic read_direction();
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_DIRECTION;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    if (got !== 32'(sb.direction))
      sb.report($sformatf("direction readback: got %0h, want %0h", got, sb.direction));
  endtask

  function automatic logic [SDATA_W-1:0] directed_vector(input int sel);
    logic [SDATA_W-1:0] v;
    logic [SAMPLE_W-1:0] s;
    int i;
    v = '0;
    for (i = 0; i < NUM_POINTS; i++) begin
      case (sel)
        0: s = '0;
        1: s = SMAX;
        2: s = SMIN;
        3: s = (i % 2 == 0) ? SMAX : SMIN;
        4: s = (i % 2 == 0) ? SMIN : SMAX;
        5: s = (i < NUM_POINTS / 2) ? SMAX : SMIN;
        6: s = (i % 3 == 0) ? SMIN : ((i % 3 == 1) ? SMAX : '0);
        7: s = SAMPLE_W'(i * 5461 - 30000);
        8: s = (i == 5) ? SMIN : ((i == 6) ? SMAX : SAMPLE_W'(1));
        default: s = (i % 2 == 0) ? {(SAMPLE_W/2){2'b10}} : {(SAMPLE_W/2){2'b01}};
      endcase
      v[i*SAMPLE_W +: SAMPLE_W] = s;
    end
    return v;
  endfunction

  function automatic logic [SDATA_W-1:0] random_vector();
    logic [SDATA_W-1:0] v;
    logic [SAMPLE_W-1:0] s;
    int i;
    v = '0;
    for (i = 0; i < NUM_POINTS; i++) begin
      case ($urandom_range(0, 9))
        0: s = SMAX;
        1: s = SMIN;
        2: s = SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
        default: s = SAMPLE_W'($urandom);
      endcase
      v[i*SAMPLE_W +: SAMPLE_W] = s;
    end
    return v;
  endfunction

  initial begin
    int k;
    int phase;
    logic [31:0] value;
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    read_direction();

    for (k = 0; k < DIRECTED; k++) send_vector(directed_vector(k));
    s_tvalid <= 1'b0;
    drain();

    // extra bits above bit 0 and the unmapped address must not change direction
    value = $urandom;
    write_register(ADDR_DIRECTION, {value[31:1], 1'b0});
    read_direction();
    write_register(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    read_direction();
    write_register(ADDR_DIRECTION, 32'h0000_0001);
    read_direction();

    for (k = 0; k < DIRECTED; k++) send_vector(directed_vector(k));
    s_tvalid <= 1'b0;
    drain();
    write_register(ADDR_UNMAPPED, 32'h0000_0000);
    read_direction();

    for (phase = 0; phase < PHASES; phase++) begin
      value = $urandom;
      if (phase == 1) value = 32'hFFFF_FFFF;
      else if (phase == 2) value = 32'hFFFF_FFFE;
      else value[0] = phase[0];
      write_register(ADDR_DIRECTION, value);
      read_direction();
      for (k = 0; k < PHASE_ITEMS; k++) send_vector(random_vector());
      s_tvalid <= 1'b0;
      drain();
    end

    repeat (4) @(negedge clk);
    $display("fused_radix6_real_dft_tb: %0d vectors sent, %0d results checked, %0d errors",
             n_accepted, sb.checked, sb.errors);
    $display("fused_radix6_real_dft_tb: forward and backward modes, sample extremes, "
             , "register masking, bursty input and output back-pressure");
    if (sb.errors == 0)
      $display("fused_radix6_real_dft_tb: done, clean");
    else
      $display("fused_radix6_real_dft_tb: done, errors");
    $finish;
  end

endmodule
